FILE: hdl/grm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the grid rotation forward mapper.
// No dependencies.
package grm_pkg;

    localparam int ADDR_W = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_COS_COEF = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIN_COEF = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SRC_ROWS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SRC_COLS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DST_ROWS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DST_COLS = 3'd5;

    localparam logic signed [17:0] COS_RESET = 18'sd65536;
    localparam logic signed [17:0] SIN_RESET = 18'sd0;
    localparam logic [10:0] SRC_DIM_RESET = 11'd1024;
    localparam logic [11:0] DST_DIM_RESET = 12'd1024;

    typedef struct packed {
        logic signed [17:0] cos_coef;
        logic signed [17:0] sin_coef;
        logic [10:0]        src_rows;
        logic [10:0]        src_cols;
        logic [11:0]        dst_rows;
        logic [11:0]        dst_cols;
    } t_cfg;

endpackage

FILE: hdl/grm_map.sv
`timescale 1ns / 1ps
// Four-stage mapping datapath: center offset, rotate, recenter, truncate and bounds check.
// Depends on grm_pkg for the configuration struct.
module grm_map #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  grm_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  logic [9:0]    i_src_row,
    input  logic [9:0]    i_src_col,
    input  logic [7:0]    i_pixel_value,
    output logic          o_valid,
    output logic [10:0]   o_dest_row,
    output logic [10:0]   o_dest_col,
    output logic [7:0]    o_out_value,
    output logic          o_in_bounds
);
    import grm_pkg::*;

    localparam int ACC_W = FRAC_BITS + 24;
    localparam int INT_W = ACC_W - FRAC_BITS;
    localparam logic [INT_W-1:0] DST_LIM = INT_W'(2 * MAX_DIM);
    localparam logic [ACC_W-1:0] FRAC_MASK = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);

    // stage 1: offsets from source center
    logic               r_v1;
    logic signed [10:0] r_x;
    logic signed [10:0] r_y;
    logic [7:0]         r_pix1;

    // stage 2: products
    logic               r_v2;
    logic signed [28:0] r_xc;
    logic signed [28:0] r_ys;
    logic signed [28:0] r_xs;
    logic signed [28:0] r_yc;
    logic [7:0]         r_pix2;

    // stage 3: fixed-point destination coordinates
    logic                   r_v3;
    logic signed [ACC_W-1:0] r_ar;
    logic signed [ACC_W-1:0] r_ac;
    logic [7:0]             r_pix3;

    // stage 4: result
    logic        r_v4;
    logic [10:0] r_drow;
    logic [10:0] r_dcol;
    logic [7:0]  r_pix4;
    logic        r_inb;

    logic signed [ACC_W-1:0] w_cr;
    logic signed [ACC_W-1:0] w_cc;
    logic [ACC_W-1:0]        w_rnd_r;
    logic [ACC_W-1:0]        w_rnd_c;
    logic [INT_W-1:0]        w_nr;
    logic [INT_W-1:0]        w_nc;
    logic [INT_W-1:0]        w_dr;
    logic [INT_W-1:0]        w_dc;
    logic                    w_ok;

    assign w_cr = signed'(ACC_W'(i_cfg.dst_rows[11:1])) <<< FRAC_BITS;
    assign w_cc = signed'(ACC_W'(i_cfg.dst_cols[11:1])) <<< FRAC_BITS;

    // truncate toward zero: bias negative values by one ulp less than one
    assign w_rnd_r = r_ar + (r_ar[ACC_W-1] ? FRAC_MASK : '0);
    assign w_rnd_c = r_ac + (r_ac[ACC_W-1] ? FRAC_MASK : '0);
    assign w_nr = w_rnd_r[ACC_W-1:FRAC_BITS];
    assign w_nc = w_rnd_c[ACC_W-1:FRAC_BITS];

    assign w_dr = (INT_W'(i_cfg.dst_rows) > DST_LIM) ? DST_LIM : INT_W'(i_cfg.dst_rows);
    assign w_dc = (INT_W'(i_cfg.dst_cols) > DST_LIM) ? DST_LIM : INT_W'(i_cfg.dst_cols);

    assign w_ok = !w_nr[INT_W-1] && (w_nr < w_dr) && !w_nc[INT_W-1] && (w_nc < w_dc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= signed'({1'b0, i_src_row} - {1'b0, i_cfg.src_rows[10:1]});
        r_y    <= signed'({1'b0, i_src_col} - {1'b0, i_cfg.src_cols[10:1]});
        r_pix1 <= i_pixel_value;

        r_xc   <= r_x * i_cfg.cos_coef;
        r_ys   <= r_y * i_cfg.sin_coef;
        r_xs   <= r_x * i_cfg.sin_coef;
        r_yc   <= r_y * i_cfg.cos_coef;
        r_pix2 <= r_pix1;

        r_ar   <= ACC_W'(r_xc) - ACC_W'(r_ys) + w_cr;
        r_ac   <= ACC_W'(r_xs) + ACC_W'(r_yc) + w_cc;
        r_pix3 <= r_pix2;

        r_drow <= w_ok ? w_nr[10:0] : 11'd0;
        r_dcol <= w_ok ? w_nc[10:0] : 11'd0;
        r_inb  <= w_ok;
        r_pix4 <= r_pix3;
    end

    assign o_valid     = r_v4;
    assign o_dest_row  = r_drow;
    assign o_dest_col  = r_dcol;
    assign o_out_value = r_pix4;
    assign o_in_bounds = r_inb;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##4 o_valid)
        else $error("request did not complete after four cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_valid ##1 !i_valid ##1 !i_valid ##1 !i_valid) |=> !o_valid)
        else $error("result strobe without a request");

    a_value_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##4 (o_out_value == $past(i_pixel_value, 4)))
        else $error("pixel value lost in pipeline");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");
`endif

endmodule

FILE: hdl/grid_rotate_forward_map.sv
`timescale 1ns / 1ps
// A request accepted at a clock edge is registered through each stage of the mapping pipeline before its result strobe.
// Throughput: one request per cycle; busy stays low, the four-stage mapping pipeline
// never holds off a request and the receiver takes every result as it appears.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults.
// Top level: APB register file and the mapping pipeline; depends on grm_pkg and grm_map.
module grid_rotate_forward_map #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [grm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic [9:0]                 i_src_row,
    input  logic [9:0]                 i_src_col,
    input  logic [7:0]                 i_pixel_value,
    output logic                       o_done,
    output logic [10:0]                o_dest_row,
    output logic [10:0]                o_dest_col,
    output logic [7:0]                 o_out_value,
    output logic                       o_in_bounds
);
    import grm_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_coef <= COS_RESET;
            r_cfg.sin_coef <= SIN_RESET;
            r_cfg.src_rows <= SRC_DIM_RESET;
            r_cfg.src_cols <= SRC_DIM_RESET;
            r_cfg.dst_rows <= DST_DIM_RESET;
            r_cfg.dst_cols <= DST_DIM_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_COS_COEF: r_cfg.cos_coef <= signed'(pwdata[17:0]);
                REG_SIN_COEF: r_cfg.sin_coef <= signed'(pwdata[17:0]);
                REG_SRC_ROWS: r_cfg.src_rows <= pwdata[10:0];
                REG_SRC_COLS: r_cfg.src_cols <= pwdata[10:0];
                REG_DST_ROWS: r_cfg.dst_rows <= pwdata[11:0];
                REG_DST_COLS: r_cfg.dst_cols <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_COS_COEF: prdata = 32'(r_cfg.cos_coef);
            REG_SIN_COEF: prdata = 32'(r_cfg.sin_coef);
            REG_SRC_ROWS: prdata = 32'(r_cfg.src_rows);
            REG_SRC_COLS: prdata = 32'(r_cfg.src_cols);
            REG_DST_ROWS: prdata = 32'(r_cfg.dst_rows);
            REG_DST_COLS: prdata = 32'(r_cfg.dst_cols);
            default:      prdata = 32'd0;
        endcase
    end

    grm_map #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (start && !busy),
        .i_src_row     (i_src_row),
        .i_src_col     (i_src_col),
        .i_pixel_value (i_pixel_value),
        .o_valid       (o_done),
        .o_dest_row    (o_dest_row),
        .o_dest_col    (o_dest_col),
        .o_out_value   (o_out_value),
        .o_in_bounds   (o_in_bounds)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for grid_rotate_forward_map: random and corner pixels run through
// several rotation and grid-size settings; each result is checked against an in-bench map.
// Depends on grm_pkg and the grid_rotate_forward_map RTL.
module tb_top;
    import grm_pkg::*;

    localparam int MAX_DIM    = 1024;
    localparam int FRAC_BITS  = 16;
    localparam int DST_CLAMP  = 2 * MAX_DIM;
    localparam int LATENCY    = 4;
    localparam int CYCLE_CAP  = 600000;

    typedef struct packed {
        logic [9:0] src_row;
        logic [9:0] src_col;
        logic [7:0] pixel_value;
    } t_pixel_req;

    typedef struct packed {
        logic [10:0] dest_row;
        logic [10:0] dest_col;
        logic [7:0]  out_value;
        logic        in_bounds;
    } t_mapped_pixel;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start = 1'b0;
    logic              busy;
    logic [9:0]        i_src_row = '0;
    logic [9:0]        i_src_col = '0;
    logic [7:0]        i_pixel_value = '0;
    logic              o_done;
    logic [10:0]       o_dest_row;
    logic [10:0]       o_dest_col;
    logic [7:0]        o_out_value;
    logic              o_in_bounds;

    // shadow of the register file
    logic signed [17:0] cos_q = COS_RESET;
    logic signed [17:0] sin_q = SIN_RESET;
    logic [10:0]        src_rows_q = SRC_DIM_RESET;
    logic [10:0]        src_cols_q = SRC_DIM_RESET;
    logic [11:0]        dst_rows_q = DST_DIM_RESET;
    logic [11:0]        dst_cols_q = DST_DIM_RESET;

    t_pixel_req    src_pixel_q[$];
    t_mapped_pixel mapped_q[$];
    int            n_fail = 0;
    int            gap_left = 0;
    int            calm_left = 0;
    int            cycle_cnt = 0;

    grid_rotate_forward_map #(
        .MAX_DIM  (MAX_DIM),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .i_src_row    (i_src_row),
        .i_src_col    (i_src_col),
        .i_pixel_value(i_pixel_value),
        .o_done       (o_done),
        .o_dest_row   (o_dest_row),
        .o_dest_col   (o_dest_col),
        .o_out_value  (o_out_value),
        .o_in_bounds  (o_in_bounds)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("grid_rotate_forward_map test failed");
            $finish;
        end
    end

    // fixed point to integer, rounding toward zero
    function automatic longint trunc_fix(input longint a);
        if (a >= 0) begin
            return a >>> FRAC_BITS;
        end
        return -((-a) >>> FRAC_BITS);
    endfunction

    function automatic t_mapped_pixel rotate_pixel(input t_pixel_req px);
        t_mapped_pixel m;
        longint x, y, acc_row, acc_col, row_i, col_i, row_lim, col_lim;
        x = longint'(px.src_row) - longint'(src_rows_q >> 1);
        y = longint'(px.src_col) - longint'(src_cols_q >> 1);
        acc_row = x * longint'(cos_q) - y * longint'(sin_q)
                  + (longint'(dst_rows_q >> 1) <<< FRAC_BITS);
        acc_col = x * longint'(sin_q) + y * longint'(cos_q)
                  + (longint'(dst_cols_q >> 1) <<< FRAC_BITS);
        row_i = trunc_fix(acc_row);
        col_i = trunc_fix(acc_col);
        row_lim = (dst_rows_q > DST_CLAMP) ? DST_CLAMP : longint'(dst_rows_q);
        col_lim = (dst_cols_q > DST_CLAMP) ? DST_CLAMP : longint'(dst_cols_q);
        m.in_bounds = (row_i >= 0) && (row_i < row_lim) && (col_i >= 0) && (col_i < col_lim);
        m.dest_row = m.in_bounds ? row_i[10:0] : 11'd0;
        m.dest_col = m.in_bounds ? col_i[10:0] : 11'd0;
        m.out_value = px.pixel_value;
        return m;
    endfunction

    // mostly back to back or short gaps, occasional long ones and calm stretches
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_pixel_req req;
        logic       start_nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else begin
            start_nxt = start;
            if (start && !busy) begin
                mapped_q.insert(mapped_q.size(),
                                rotate_pixel({i_src_row, i_src_col, i_pixel_value}));
                start_nxt = 1'b0;
            end
            if (!start_nxt) begin
                if (gap_left == 0 && src_pixel_q.size() > 0) begin
                    req = src_pixel_q.pop_front();
                    i_src_row <= req.src_row;
                    i_src_col <= req.src_col;
                    i_pixel_value <= req.pixel_value;
                    start_nxt = 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    if (gap_left > 0) gap_left <= gap_left - 1;
                    i_src_row <= 10'($urandom);
                    i_src_col <= 10'($urandom);
                    i_pixel_value <= 8'($urandom);
                end
            end
            start <= start_nxt;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_mapped_pixel exp_px;
        if (i_rst_n && o_done) begin
            if (mapped_q.size() == 0) begin
                $error("result with no request outstanding: row %0d col %0d",
                       o_dest_row, o_dest_col);
                n_fail++;
            end else begin
                exp_px = mapped_q.pop_front();
                if (o_dest_row !== exp_px.dest_row) begin
                    $error("dest_row: expected %0d, got %0d", exp_px.dest_row, o_dest_row);
                    n_fail++;
                end
                if (o_dest_col !== exp_px.dest_col) begin
                    $error("dest_col: expected %0d, got %0d", exp_px.dest_col, o_dest_col);
                    n_fail++;
                end
                if (o_out_value !== exp_px.out_value) begin
                    $error("out_value: expected %0d, got %0d", exp_px.out_value, o_out_value);
                    n_fail++;
                end
                if (o_in_bounds !== exp_px.in_bounds) begin
                    $error("in_bounds: expected %0d, got %0d", exp_px.in_bounds, o_in_bounds);
                    n_fail++;
                end
            end
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_COS_COEF: cos_q = val[17:0];
            REG_SIN_COEF: sin_q = val[17:0];
            REG_SRC_ROWS: src_rows_q = val[10:0];
            REG_SRC_COLS: src_cols_q = val[10:0];
            REG_DST_ROWS: dst_rows_q = val[11:0];
            REG_DST_COLS: dst_cols_q = val[11:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int c, input int s, input int sr, input int sc,
                              input int dr, input int dc);
        write_reg(REG_COS_COEF, c);
        write_reg(REG_SIN_COEF, s);
        write_reg(REG_SRC_ROWS, sr);
        write_reg(REG_SRC_COLS, sc);
        write_reg(REG_DST_ROWS, dr);
        write_reg(REG_DST_COLS, dc);
    endtask

    function automatic int rand_coef();
        int sel;
        int angles[5];
        angles = '{65536, 0, -65536, 46341, -46341};
        sel = $urandom_range(0, 3);
        if (sel == 1) return $urandom_range(0, 18'h3FFFF);
        if (sel == 2) return angles[$urandom_range(0, 4)];
        return int'($urandom_range(0, 131072)) - 65536;
    endfunction

    function automatic int rand_src_dim();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
    endfunction

    function automatic int rand_dst_dim();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 2048);
    endfunction

    function automatic logic [9:0] rand_index();
        case ($urandom_range(0, 9))
            0:       return 10'($urandom_range(0, 3));
            1:       return 10'($urandom_range(1020, 1023));
            default: return 10'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input logic [9:0] r, input logic [9:0] c, input logic [7:0] v);
        src_pixel_q.insert(src_pixel_q.size(),
                           t_pixel_req'{src_row: r, src_col: c, pixel_value: v});
    endtask

    // sampled away from the rising edge so the driver's updates have settled
    task automatic wait_idle();
        while (src_pixel_q.size() != 0 || start || mapped_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(input int n_items);
        push_pixel(10'd0, 10'd0, 8'd0);
        push_pixel(10'd1023, 10'd1023, 8'd255);
        push_pixel(10'd0, 10'd1023, 8'($urandom));
        push_pixel(10'd1023, 10'd0, 8'($urandom));
        for (int i = 0; i < n_items; i++) push_pixel(rand_index(), rand_index(), 8'($urandom));
        wait_idle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity mapping out of reset
        push_pixel(10'd0, 10'd0, 8'd0);
        push_pixel(10'd1023, 10'd1023, 8'd255);
        push_pixel(10'd512, 10'd512, 8'hAA);
        push_pixel(10'd0, 10'd1023, 8'h55);
        push_pixel(10'd1023, 10'd0, 8'h0F);
        push_pixel(10'h2AA, 10'h155, 8'hF0);
        push_pixel(10'h155, 10'h2AA, 8'd1);
        push_pixel(10'd511, 10'd513, 8'd128);
        wait_idle();

        set_config(0, 65536, 1024, 1024, 1024, 1024);
        run_phase(60);
        set_config(-65536, 0, 1024, 1024, 1024, 1024);
        run_phase(60);
        set_config(46341, 46341, 1024, 1024, 1449, 1449);
        run_phase(60);
        // coefficients past range, zero source size, oversized destination
        set_config(131071, -131072, 0, 0, 4095, 4095);
        run_phase(60);
        set_config(-65536, -65536, 1, 1, 0, 0);
        run_phase(40);
        set_config(32768, -56756, 2047, 2047, 2048, 2048);
        run_phase(60);
        set_config(-32768, 32768, 1, 2, 1, 1);
        run_phase(40);

        for (int p = 0; p < 9; p++) begin
            set_config(rand_coef(), rand_coef(), rand_src_dim(), rand_src_dim(),
                       rand_dst_dim(), rand_dst_dim());
            run_phase(80);
        end

        wait_idle();
        repeat (2 * LATENCY + 4) @(posedge i_clk);
        if (n_fail == 0 && mapped_q.size() == 0) begin
            $display("grid_rotate_forward_map test passed");
        end else begin
            $display("grid_rotate_forward_map test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/grm_pkg.sv
hdl/grm_map.sv
hdl/grid_rotate_forward_map.sv
bench/tb_top.sv
